[rtl/rotation_matrix_to_quaternion_unit_defines.svh]
// Assertion macros for the checker.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
// Assert that an antecedent implies a consequent on the next cycle.
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that a condition holds every cycle out of reset.
`define RMQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

[rtl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants for the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;
    localparam int DW = 16;

    // Fraction bits of every matrix entry and quaternion component (Q2.14).
    localparam int FRAC_BITS = 14;

    typedef struct packed {
        logic signed [DW-1:0] m00;
        logic signed [DW-1:0] m01;
        logic signed [DW-1:0] m02;
        logic signed [DW-1:0] m10;
        logic signed [DW-1:0] m11;
        logic signed [DW-1:0] m12;
        logic signed [DW-1:0] m20;
        logic signed [DW-1:0] m21;
        logic signed [DW-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [DW-1:0] quat_w;
        logic signed [DW-1:0] quat_x;
        logic signed [DW-1:0] quat_y;
        logic signed [DW-1:0] quat_z;
        logic [1:0]           largest_pick;
        logic                 clipped;
    } quat_t;

    localparam logic [1:0] PICK_W = 2'd0;
    localparam logic [1:0] PICK_X = 2'd1;
    localparam logic [1:0] PICK_Y = 2'd2;
    localparam logic [1:0] PICK_Z = 2'd3;

    // Front to back item: pick, sum to root, three signed numerators.
    typedef struct packed {
        logic [1:0]         pick;
        logic [19:0]        s;
        logic signed [17:0] d0;
        logic signed [17:0] d1;
        logic signed [17:0] d2;
    } job_t;
endpackage

[rtl/rotation_matrix_to_quaternion_unit.sv]
// Done follows front, queue, root, divide, output regs; the beat is taken at the next edge.
// Throughput: one matrix per cycle; busy is always low.
// Root and divides are fully pipelined, one bit per stage.
// The result cannot be stalled: done is high for one cycle per beat.
// Reset (rst_n low, asynchronous) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a Q2.14 rotation matrix into a saturated quaternion.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit
    import rmq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  mat_t  mat,
    output logic  done,
    output quat_t result
);
    logic fr_vld, qu_vld;
    job_t fr_job, qu_job;

    assign busy = 1'b0;

    rmq_front u_front (
        .clk(clk), .rst_n(rst_n), .in_vld(start & ~busy), .mat(mat),
        .job_vld(fr_vld), .job(fr_job)
    );

    rmq_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_vld(fr_vld), .in_job(fr_job),
        .out_vld(qu_vld), .out_job(qu_job)
    );

    rmq_back u_back (
        .clk(clk), .rst_n(rst_n), .job_vld(qu_vld), .job(qu_job),
        .done(done), .res(result)
    );
endmodule

[rtl/rmq_front.sv]
// ----------------------------------------------------------------------------
// rmq_front
// Forms the diagonal sums, picks the largest and gathers the numerators.
// ----------------------------------------------------------------------------
module rmq_front
    import rmq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_vld,
    input  mat_t mat,
    output logic job_vld,
    output job_t job
);
    logic signed [17:0] vw, vx, vy, vz, best, bx, by;
    logic [1:0]         pk, px, py;
    logic signed [17:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [19:0] s_full;
    job_t               job_next;
    job_t               job_reg;
    logic               vld_reg;

    // Sign-extended entries.
    assign a00 = 18'(mat.m00);
    assign a01 = 18'(mat.m01);
    assign a02 = 18'(mat.m02);
    assign a10 = 18'(mat.m10);
    assign a11 = 18'(mat.m11);
    assign a12 = 18'(mat.m12);
    assign a20 = 18'(mat.m20);
    assign a21 = 18'(mat.m21);
    assign a22 = 18'(mat.m22);

    // Diagonal sums and the strict largest search.
    always_comb
    begin
        vw = a00 + a11 + a22;
        vx = a00 - a11 - a22;
        vy = a11 - a00 - a22;
        vz = a22 - a00 - a11;
        bx = (vx > vw) ? vx : vw;
        px = (vx > vw) ? PICK_X : PICK_W;
        by = (vy > bx) ? vy : bx;
        py = (vy > bx) ? PICK_Y : px;
        best = (vz > by) ? vz : by;
        pk = (vz > by) ? PICK_Z : py;
        s_full = 20'(best) + 20'(64'sd1 <<< FRAC_BITS);
        job_next.pick = pk;
        job_next.s = (s_full < 20'sd1) ? 20'd1 : 20'(s_full);
        unique case (pk)
            PICK_W:
            begin
                job_next.d0 = a12 - a21;
                job_next.d1 = a20 - a02;
                job_next.d2 = a01 - a10;
            end
            PICK_X:
            begin
                job_next.d0 = a12 - a21;
                job_next.d1 = a01 + a10;
                job_next.d2 = a20 + a02;
            end
            PICK_Y:
            begin
                job_next.d0 = a20 - a02;
                job_next.d1 = a01 + a10;
                job_next.d2 = a12 + a21;
            end
            default:
            begin
                job_next.d0 = a01 - a10;
                job_next.d1 = a20 + a02;
                job_next.d2 = a12 + a21;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign job_vld = vld_reg;
    assign job     = job_reg;
endmodule

[rtl/rmq_queue.sv]
// ----------------------------------------------------------------------------
// rmq_queue
// Short delay line between front and back; neither side stalls.
// ----------------------------------------------------------------------------
module rmq_queue
    import rmq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_vld,
    input  job_t in_job,
    output logic out_vld,
    output job_t out_job
);
    logic vld_reg;
    job_t job_reg;

    // One beat of storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            job_reg <= in_job;
        end
    end

    assign out_vld = vld_reg;
    assign out_job = job_reg;
endmodule

[rtl/rmq_back.sv]
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root, pipelined divides and output saturation.
// ----------------------------------------------------------------------------
module rmq_back
    import rmq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  job_vld,
    input  job_t  job,
    output logic  done,
    output quat_t res
);
    // Radicand is below 2^34; root fits 17 bits.
    localparam int RW = 34;
    localparam int BW = 17;
    localparam int QB = 17;  // quotient bits
    localparam int NW = 18 + FRAC_BITS + 1;
    localparam int DENW = BW + 2;

    // Root pipeline: one result bit per stage.
    logic [BW:0]          sv_vld;
    logic [RW-1:0]        sq_rem  [BW+1];
    logic [BW-1:0]        sq_root [BW+1];
    job_t                 sq_job  [BW+1];

    assign sv_vld[0]  = job_vld;
    assign sq_rem[0]  = RW'(64'(job.s) << (FRAC_BITS - 2));
    assign sq_root[0] = '0;
    assign sq_job[0]  = job;

    for (genvar i = 0; i < BW; i++)
    begin : g_sq
        localparam int SH = 2 * (BW - 1 - i);
        logic [RW+1:0] trial;
        logic [RW-1:0] rem_next;
        logic [BW-1:0] root_next;
        logic          vld_reg;
        logic [RW-1:0] rem_reg;
        logic [BW-1:0] root_reg;
        job_t          job_reg;

        always_comb
        begin
            trial = ({2'b0, RW'(sq_root[i])} << (BW - i)) | ((RW + 2)'(1) << SH);
            if ({2'b0, sq_rem[i]} >= trial)
            begin
                rem_next  = sq_rem[i] - RW'(trial);
                root_next = sq_root[i] | (BW'(1) << (BW - 1 - i));
            end
            else
            begin
                rem_next  = sq_rem[i];
                root_next = sq_root[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= sv_vld[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            job_reg  <= sq_job[i];
        end

        assign sv_vld[i+1]  = vld_reg;
        assign sq_rem[i+1]  = rem_reg;
        assign sq_root[i+1] = root_reg;
        assign sq_job[i+1]  = job_reg;
    end

    // Divide setup: magnitudes shifted, plus half the divisor.
    logic [BW-1:0]   b;
    logic [DENW-1:0] den;
    assign b   = (sq_root[BW] == '0) ? BW'(1) : sq_root[BW];
    assign den = {b, 2'b00};

    logic [NW-1:0]      dv_num [3][QB+1];
    logic [QB-1:0]      dv_q   [3][QB+1];
    logic [2:0]         dv_neg [QB+1];
    logic [BW-1:0]      dv_b   [QB+1];
    logic [1:0]         dv_pk  [QB+1];
    logic [QB:0]        dv_vld;
    logic signed [17:0] dv_d   [3];

    assign dv_d[0] = sq_job[BW].d0;
    assign dv_d[1] = sq_job[BW].d1;
    assign dv_d[2] = sq_job[BW].d2;

    for (genvar k = 0; k < 3; k++)
    begin : g_setup
        logic [17:0] mag;
        assign mag          = dv_d[k][17] ? 18'(-dv_d[k]) : 18'(dv_d[k]);
        assign dv_neg[0][k] = dv_d[k][17];
        assign dv_num[k][0] = (NW'(mag) << FRAC_BITS) + NW'(den >> 1);
        assign dv_q[k][0]   = '0;
    end
    assign dv_b[0]   = b;
    assign dv_pk[0]  = sq_job[BW].pick;
    assign dv_vld[0] = sv_vld[BW];

    // Restoring divide, one quotient bit per stage for three lanes.
    for (genvar j = 0; j < QB; j++)
    begin : g_dv
        localparam int SH = QB - 1 - j;
        logic [NW-1:0]   num_next [3];
        logic [QB-1:0]   q_next   [3];
        logic [NW-1:0]   num_reg  [3];
        logic [QB-1:0]   q_reg    [3];
        logic [2:0]      neg_reg;
        logic [BW-1:0]   b_reg;
        logic [1:0]      pk_reg;
        logic            vld_reg;
        logic [NW+QB:0]  dsh;

        always_comb
        begin
            dsh = (NW + QB + 1)'({dv_b[j], 2'b00}) << SH;
            for (int k = 0; k < 3; k++)
            begin
                if ((NW + QB + 1)'(dv_num[k][j]) >= dsh)
                begin
                    num_next[k] = dv_num[k][j] - NW'(dsh);
                    q_next[k]   = dv_q[k][j] | (QB'(1) << SH);
                end
                else
                begin
                    num_next[k] = dv_num[k][j];
                    q_next[k]   = dv_q[k][j];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= dv_vld[j];
            end
        end

        always_ff @(posedge clk)
        begin
            num_reg <= num_next;
            q_reg   <= q_next;
            neg_reg <= dv_neg[j];
            b_reg   <= dv_b[j];
            pk_reg  <= dv_pk[j];
        end

        for (genvar k = 0; k < 3; k++)
        begin : g_ln
            assign dv_num[k][j+1] = num_reg[k];
            assign dv_q[k][j+1]   = q_reg[k];
        end
        assign dv_neg[j+1] = neg_reg;
        assign dv_b[j+1]   = b_reg;
        assign dv_pk[j+1]  = pk_reg;
        assign dv_vld[j+1] = vld_reg;
    end

    // Sign, saturate and place the components.
    quat_t res_next;
    quat_t res_reg;
    logic  done_reg;
    always_comb
    begin
        logic signed [QB+1:0] v [4];
        logic [3:0]           c;
        logic [1:0]           p;
        p = dv_pk[QB];
        v[0] = (QB + 2)'(dv_b[QB]);
        for (int k = 0; k < 3; k++)
        begin
            v[k+1] = dv_neg[QB][k] ? -(QB + 2)'(dv_q[k][QB]) : (QB + 2)'(dv_q[k][QB]);
        end
        for (int k = 0; k < 4; k++)
        begin
            c[k] = (v[k] > 19'sd32767) || (v[k] < -19'sd32768);
            if (v[k] > 19'sd32767)
            begin
                v[k] = 19'sd32767;
            end
            else if (v[k] < -19'sd32768)
            begin
                v[k] = -19'sd32768;
            end
        end
        res_next.largest_pick = p;
        res_next.clipped = |c;
        unique case (p)
            PICK_W:
            begin
                res_next.quat_w = DW'(v[0]);
                res_next.quat_x = DW'(v[1]);
                res_next.quat_y = DW'(v[2]);
                res_next.quat_z = DW'(v[3]);
            end
            PICK_X:
            begin
                res_next.quat_x = DW'(v[0]);
                res_next.quat_w = DW'(v[1]);
                res_next.quat_y = DW'(v[2]);
                res_next.quat_z = DW'(v[3]);
            end
            PICK_Y:
            begin
                res_next.quat_y = DW'(v[0]);
                res_next.quat_w = DW'(v[1]);
                res_next.quat_x = DW'(v[2]);
                res_next.quat_z = DW'(v[3]);
            end
            default:
            begin
                res_next.quat_z = DW'(v[0]);
                res_next.quat_w = DW'(v[1]);
                res_next.quat_x = DW'(v[2]);
                res_next.quat_y = DW'(v[3]);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;
endmodule

[rtl/rmq_checker.sv]
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks on the quaternion unit.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_unit_defines.svh"
module rmq_checker
    import rmq_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  start,
    input logic  busy,
    input logic  done,
    input quat_t result
);
    // Edges from an accepted start beat to the edge that takes its result.
    localparam int RESULT_DELAY = 37;

    logic at_bound;
    logic pick_neg;

    // Some component sits on a saturation bound.
    assign at_bound = (result.quat_w == 16'sh7fff) || (result.quat_w == 16'sh8000) ||
                      (result.quat_x == 16'sh7fff) || (result.quat_x == 16'sh8000) ||
                      (result.quat_y == 16'sh7fff) || (result.quat_y == 16'sh8000) ||
                      (result.quat_z == 16'sh7fff) || (result.quat_z == 16'sh8000);

    // Sign of the component named by largest_pick.
    always_comb
    begin
        case (result.largest_pick)
            PICK_W:  pick_neg = result.quat_w[DW-1];
            PICK_X:  pick_neg = result.quat_x[DW-1];
            PICK_Y:  pick_neg = result.quat_y[DW-1];
            default: pick_neg = result.quat_z[DW-1];
        endcase
    end

    // The unit never refuses a beat.
    `RMQ_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised")
    // A clipped beat has a component on a bound.
    `RMQ_ASSERT_ALWAYS(a_clip, clk, rst_n, !done || !result.clipped || at_bound, "clip")
    // The picked component is never negative.
    `RMQ_ASSERT_ALWAYS(a_pick_pos, clk, rst_n, !done || !pick_neg, "picked component negative")
    // Done is silent just after reset while nothing was started.
    `RMQ_ASSERT_NEXT(a_no_spurious, clk, rst_n, $rose(rst_n), !done, "done after reset")
    // Every result beat follows an accepted start beat at the fixed latency.
    `RMQ_ASSERT_ALWAYS(a_done_follows, clk, rst_n, !done || $past(start && !busy, RESULT_DELAY), "done without start")
endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .result(result)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives rotation matrices into the quaternion unit and checks every result
// beat against an in-bench fixed-point conversion, in order.
// ----------------------------------------------------------------------------
module testbench;
    import rmq_pkg::*;

    localparam int FRAC = FRAC_BITS;
    localparam int LATENCY = 36;
    localparam int RANDOM_ITEMS = 1800;
    localparam logic signed [15:0] ONE = 16'sd16384;

    typedef struct {
        mat_t  mat;
        logic  known;
        quat_t quat;
    } stim_row_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    mat_t  mat;
    logic  done;
    quat_t result;

    quat_t expected_quats[$];
    stim_row_t stim_table[$];
    int    error_count;

    rotation_matrix_to_quaternion_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .mat    (mat),
        .done   (done),
        .result (result)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root, rounded down.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Numerator times 2^F over four times the root, rounded half away from zero.
    function automatic longint round_quotient(longint num, longint unsigned root);
        longint unsigned mag;
        longint unsigned den;
        longint unsigned quo;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        den = 4 * root;
        quo = ((mag << FRAC) + (den >> 1)) / den;
        return (num < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    // Clamp to 16 bits and note any clamping.
    function automatic logic signed [15:0] clamp16(longint v, inout logic clip);
        if (v > 32767)
        begin
            clip = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768)
        begin
            clip = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Shepperd conversion of one matrix.
    function automatic quat_t matrix_to_quat(mat_t m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint sums[4];
        longint comp[4];
        longint peak;
        longint unsigned root;
        logic [1:0] pick;
        logic clip;
        quat_t q;
        a00 = m.m00; a01 = m.m01; a02 = m.m02;
        a10 = m.m10; a11 = m.m11; a12 = m.m12;
        a20 = m.m20; a21 = m.m21; a22 = m.m22;
        sums[0] = a00 + a11 + a22;
        sums[1] = a00 - a11 - a22;
        sums[2] = a11 - a00 - a22;
        sums[3] = a22 - a00 - a11;
        peak = sums[0];
        pick = PICK_W;
        for (int k = 1; k < 4; k++)
        begin
            if (sums[k] > peak)
            begin
                peak = sums[k];
                pick = k[1:0];
            end
        end
        peak = peak + (64'sd1 << FRAC);
        if (peak < 1)
            peak = 1;
        root = int_sqrt(longint'(peak) << (FRAC - 2));
        if (root == 0)
            root = 1;
        case (pick)
            PICK_W:
            begin
                comp[0] = root;
                comp[1] = round_quotient(a12 - a21, root);
                comp[2] = round_quotient(a20 - a02, root);
                comp[3] = round_quotient(a01 - a10, root);
            end
            PICK_X:
            begin
                comp[1] = root;
                comp[0] = round_quotient(a12 - a21, root);
                comp[2] = round_quotient(a01 + a10, root);
                comp[3] = round_quotient(a20 + a02, root);
            end
            PICK_Y:
            begin
                comp[2] = root;
                comp[0] = round_quotient(a20 - a02, root);
                comp[1] = round_quotient(a01 + a10, root);
                comp[3] = round_quotient(a12 + a21, root);
            end
            default:
            begin
                comp[3] = root;
                comp[0] = round_quotient(a01 - a10, root);
                comp[1] = round_quotient(a20 + a02, root);
                comp[2] = round_quotient(a12 + a21, root);
            end
        endcase
        clip = 1'b0;
        q.quat_w = clamp16(comp[0], clip);
        q.quat_x = clamp16(comp[1], clip);
        q.quat_y = clamp16(comp[2], clip);
        q.quat_z = clamp16(comp[3], clip);
        q.largest_pick = pick;
        q.clipped = clip;
        return q;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic mat_t make_mat(int v00, int v01, int v02, int v10, int v11,
                                      int v12, int v20, int v21, int v22);
        mat_t m;
        m.m00 = v00[15:0]; m.m01 = v01[15:0]; m.m02 = v02[15:0];
        m.m10 = v10[15:0]; m.m11 = v11[15:0]; m.m12 = v12[15:0];
        m.m20 = v20[15:0]; m.m21 = v21[15:0]; m.m22 = v22[15:0];
        return m;
    endfunction

    function automatic quat_t make_quat(int w, int x, int y, int z, logic [1:0] p,
                                        logic c);
        quat_t q;
        q.quat_w = w[15:0]; q.quat_x = x[15:0]; q.quat_y = y[15:0];
        q.quat_z = z[15:0]; q.largest_pick = p; q.clipped = c;
        return q;
    endfunction

    task automatic add_row(mat_t m, logic known, quat_t q);
        stim_row_t r;
        r.mat = m;
        r.known = known;
        r.quat = q;
        stim_table.insert(stim_table.size(), r);
    endtask

    // One random entry between -1.0 and just under 1.0.
    function automatic logic signed [15:0] rand_entry();
        int raw;
        raw = int'($urandom_range(0, 32767)) - 16384;
        return raw[15:0];
    endfunction

    // A random rotation-like matrix: one diagonal term set to 1.0, random rest.
    function automatic mat_t near_rotation();
        mat_t m;
        int dom;
        m = make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0);
        m.m00 = rand_entry();
        m.m11 = rand_entry();
        m.m22 = rand_entry();
        m.m01 = rand_entry();
        m.m02 = rand_entry();
        m.m10 = rand_entry();
        m.m12 = rand_entry();
        m.m20 = rand_entry();
        m.m21 = rand_entry();
        dom = int'($urandom_range(0, 2));
        if (dom == 0) m.m00 = ONE;
        if (dom == 1) m.m11 = ONE;
        if (dom == 2) m.m22 = ONE;
        return m;
    endfunction

    // Hand one matrix over, with occasional bursts of idle cycles.
    task automatic send_matrix(mat_t m, bit allow_idle);
        if (allow_idle && $urandom_range(0, 7) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        start <= 1'b1;
        mat   <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_quats.insert(expected_quats.size(), matrix_to_quat(m));
        @(negedge clk);
    endtask

    // Result checking on every rising edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_quats.size() == 0)
            begin
                report_mismatch("result beats pending", 1, 0);
            end
            else
            begin
                quat_t want;
                want = expected_quats.pop_front();
                if (result.quat_w !== want.quat_w)
                    report_mismatch("quat_w", result.quat_w, want.quat_w);
                if (result.quat_x !== want.quat_x)
                    report_mismatch("quat_x", result.quat_x, want.quat_x);
                if (result.quat_y !== want.quat_y)
                    report_mismatch("quat_y", result.quat_y, want.quat_y);
                if (result.quat_z !== want.quat_z)
                    report_mismatch("quat_z", result.quat_z, want.quat_z);
                if (result.largest_pick !== want.largest_pick)
                    report_mismatch("largest_pick", result.largest_pick,
                                    want.largest_pick);
                if (result.clipped !== want.clipped)
                    report_mismatch("clipped", result.clipped, want.clipped);
            end
        end
    end

    // Main stimulus.
    initial
    begin
        int tail_cycles;
        mat_t m;
        logic [159:0] raw_bits;
        error_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        mat = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows: identity, axis flips, ties, extremes, saturation.
        add_row(make_mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1'b1,
                make_quat(16384, 0, 0, 0, PICK_W, 1'b0));
        add_row(make_mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b1,
                make_quat(0, 16384, 0, 0, PICK_X, 1'b0));
        add_row(make_mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1'b1,
                make_quat(0, 0, 16384, 0, PICK_Y, 1'b0));
        add_row(make_mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1'b1,
                make_quat(0, 0, 0, 16384, PICK_Z, 1'b0));
        add_row(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_mat(0, -16384, 0, 16384, 0, 0, 0, 0, 16384), 1'b0, '0);
        add_row(make_mat(0, 16384, 0, 16384, 0, 0, 0, 0, -16384), 1'b0, '0);
        add_row(make_mat(0, 0, 16384, 0, -16384, 0, 16384, 0, 0), 1'b0, '0);
        add_row(make_mat(-16384, 0, 0, 0, 0, 16384, 0, 16384, 0), 1'b0, '0);
        add_row(make_mat(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                         -32768, -32768), 1'b0, '0);
        add_row(make_mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                         32767), 1'b0, '0);
        add_row(make_mat(-32768, 32767, -32768, 32767, -32768, 32767, -32768,
                         32767, -32768), 1'b0, '0);
        add_row(make_mat(-32768, 32767, -32768, -32768, -32768, 32767, 32767,
                         -32768, -32768), 1'b0, '0);
        add_row(make_mat(-32768, -32768, 32767, 32767, -32768, -32768, -32768,
                         32767, 32767), 1'b0, '0);
        add_row(make_mat(0, 0, 0, 0, -32768, 0, 0, 0, 32767), 1'b0, '0);
        add_row(make_mat(16384, 16384, 0, 0, 16384, 0, 0, 0, 0), 1'b0, '0);

        foreach (stim_table[i])
        begin
            if (stim_table[i].known &&
                matrix_to_quat(stim_table[i].mat) !== stim_table[i].quat)
            begin
                report_mismatch($sformatf("directed row %0d prediction", i), 0, 1);
            end
            send_matrix(stim_table[i].mat, 1'b1);
        end

        // Random part; most matrices are near rotations, the rest raw bits.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                raw_bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
                m = raw_bits[143:0];
            end
            else
                m = near_rotation();
            send_matrix(m, n < RANDOM_ITEMS - 200);
        end
        start <= 1'b0;

        // Drain.
        while (expected_quats.size() != 0)
            @(posedge clk);
        tail_cycles = LATENCY + 10;
        repeat (tail_cycles) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_queue.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion_unit.sv
rtl/rmq_checker.sv
tb/testbench.sv
